// ===== rtl/xibe_pkg.sv =====
// Shared types, opcodes and constants of the x86-64 instruction byte encoder.
package xibe_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int MAX_BYTES          = 11;
  localparam int QDEPTH             = 2;
  localparam int QPTR_W             = $clog2(QDEPTH);

  // request operations
  localparam logic [4:0] CMD_JMP8      = 5'd0;
  localparam logic [4:0] CMD_JCC8      = 5'd1;
  localparam logic [4:0] CMD_JMP32     = 5'd2;
  localparam logic [4:0] CMD_JCC32     = 5'd3;
  localparam logic [4:0] CMD_LABEL     = 5'd4;
  localparam logic [4:0] CMD_RET       = 5'd5;
  localparam logic [4:0] CMD_SUBIMM    = 5'd6;
  localparam logic [4:0] CMD_ADDIMM    = 5'd7;
  localparam logic [4:0] CMD_ALU_FIRST = 5'd8;
  localparam logic [4:0] CMD_ALU_LAST  = 5'd14;
  localparam logic [4:0] CMD_MUL_FIRST = 5'd15;
  localparam logic [4:0] CMD_MUL_LAST  = 5'd18;
  localparam logic [4:0] CMD_MOV       = 5'd19;
  localparam logic [4:0] CMD_STORE     = 5'd20;
  localparam logic [4:0] CMD_LOAD      = 5'd21;
  localparam logic [4:0] CMD_PUSH      = 5'd22;
  localparam logic [4:0] CMD_POP       = 5'd23;
  localparam logic [4:0] CMD_PUSHIMM   = 5'd24;
  localparam logic [4:0] CMD_STACKLOAD = 5'd25;
  localparam logic [4:0] CMD_LEA       = 5'd26;

  // register numbers
  localparam logic [2:0] REG_RAX = 3'd0;
  localparam logic [2:0] REG_RCX = 3'd1;
  localparam logic [2:0] REG_RDX = 3'd2;
  localparam logic [2:0] REG_RBX = 3'd3;
  localparam logic [2:0] REG_RSP = 3'd4;
  localparam logic [2:0] REG_RBP = 3'd5;

  // size codes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_QWORD = 2'd3;

  // fixed bytes
  localparam logic [7:0] OP_REX_W    = 8'h48;
  localparam logic [7:0] OP_OPSIZE   = 8'h66;
  localparam logic [7:0] OP_REX      = 8'h40;
  localparam logic [7:0] OP_GRP1_IB  = 8'h83;
  localparam logic [7:0] OP_GRP1_ID  = 8'h81;
  localparam logic [7:0] OP_PUSH_IB  = 8'h6A;
  localparam logic [7:0] OP_PUSH_ID  = 8'h68;
  localparam logic [7:0] OP_MOV_RI   = 8'hB8;
  localparam logic [7:0] OP_SIB_RSP  = 8'h24;
  localparam logic [7:0] DISP8_PH    = 8'h7E;
  localparam logic [7:0] DISP32_PH0  = 8'hFB;
  localparam logic [7:0] DISP32C_PH0 = 8'hFA;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_JMP8     = 8'hEB;
  localparam logic [7:0] OP_JMP32    = 8'hE9;
  localparam logic [7:0] OP_JCC8     = 8'h70;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_JCC32    = 8'h80;

  localparam logic [3:0] PATCH_NONE = 4'hF;

  typedef enum logic [1:0] {
    KIND_BYTES = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_LABEL = 2'd3
  } kind_t;

  // one classified request, as handed from front to back
  typedef struct packed {
    kind_t                       kind;
    logic [MAX_BYTES-1:0][7:0]   bytes;
    logic [3:0]                  nbytes;
    logic [3:0]                  patch_idx;
    logic                        term;
  } desc_t;

  function automatic logic [7:0] alu_opcode(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h00;
      3'd1:    r = 8'h28;
      3'd2:    r = 8'h38;
      3'd3:    r = 8'h84;
      3'd4:    r = 8'h30;
      3'd5:    r = 8'h20;
      3'd6:    r = 8'h08;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] mul_modrm(input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0:    r = 8'hE0;
      2'd1:    r = 8'hE8;
      2'd2:    r = 8'hF0;
      default: r = 8'hF8;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/xibe_front.sv =====
// Front end: accepts requests and classifies them into byte descriptors.
module xibe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          in_cmd,
  input  logic [2:0]          in_dst_reg,
  input  logic [2:0]          in_src_reg,
  input  logic [1:0]          in_size_code,
  input  logic [3:0]          in_cond,
  input  logic signed [63:0]  in_imm,
  output logic                desc_valid,
  input  logic                desc_ready,
  output xibe_pkg::desc_t     desc
);

  logic            front_v_r, front_v_nxt;
  xibe_pkg::desc_t desc_r, desc_nxt;
  logic            accept, push;

  logic [63:0] uimm;
  logic        fits8, fits32, imm_zero;
  logic [3:0]  n;
  logic [7:0]  r_bits;
  logic [7:0]  ext;
  logic [2:0]  d, s;

  assign uimm     = $unsigned(in_imm);
  assign fits8    = (&uimm[63:7]) | ~(|uimm[63:7]);
  assign fits32   = (&uimm[63:31]) | ~(|uimm[63:31]);
  assign imm_zero = ~(|uimm);
  assign d        = in_dst_reg;
  assign s        = in_src_reg;

  always_comb begin
    desc_nxt           = '0;
    desc_nxt.kind      = xibe_pkg::KIND_BYTES;
    desc_nxt.patch_idx = xibe_pkg::PATCH_NONE;
    n                  = '0;
    r_bits             = (d == xibe_pkg::REG_RAX) ? 8'h00 : 8'h10;
    ext                = '0;

    if (in_cmd == xibe_pkg::CMD_JMP8) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_JMP8;
      desc_nxt.bytes[1] = xibe_pkg::DISP8_PH;
      n = 4'd2; desc_nxt.patch_idx = 4'd1; desc_nxt.term = 1'b1;
    end else if (in_cmd == xibe_pkg::CMD_JCC8) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_JCC8 | {4'h0, in_cond};
      desc_nxt.bytes[1] = xibe_pkg::DISP8_PH;
      n = 4'd2; desc_nxt.patch_idx = 4'd1; desc_nxt.term = 1'b1;
    end else if (in_cmd == xibe_pkg::CMD_JMP32) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_JMP32;
      desc_nxt.bytes[1] = xibe_pkg::DISP32_PH0;
      desc_nxt.bytes[2] = 8'hFF;
      desc_nxt.bytes[3] = 8'hFF;
      desc_nxt.bytes[4] = 8'h7F;
      n = 4'd5; desc_nxt.patch_idx = 4'd1; desc_nxt.term = 1'b1;
    end else if (in_cmd == xibe_pkg::CMD_JCC32) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_ESC;
      desc_nxt.bytes[1] = xibe_pkg::OP_JCC32 | {4'h0, in_cond};
      desc_nxt.bytes[2] = xibe_pkg::DISP32C_PH0;
      desc_nxt.bytes[3] = 8'hFF;
      desc_nxt.bytes[4] = 8'hFF;
      desc_nxt.bytes[5] = 8'h7F;
      n = 4'd6; desc_nxt.patch_idx = 4'd2; desc_nxt.term = 1'b1;
    end else if (in_cmd == xibe_pkg::CMD_LABEL) begin
      desc_nxt.kind = xibe_pkg::KIND_LABEL;
    end else if (in_cmd == xibe_pkg::CMD_RET) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_RET;
      n = 4'd1; desc_nxt.term = 1'b1;
    end else if (in_cmd == xibe_pkg::CMD_SUBIMM || in_cmd == xibe_pkg::CMD_ADDIMM) begin
      ext = (in_cmd == xibe_pkg::CMD_SUBIMM) ? 8'hE8 : 8'hC0;
      if (imm_zero) begin
        desc_nxt.kind = xibe_pkg::KIND_EMPTY;
      end else if (uimm > 64'h7FFF_FFFF) begin
        desc_nxt.kind = xibe_pkg::KIND_ERROR;
      end else begin
        desc_nxt.bytes[0] = xibe_pkg::OP_REX_W;
        if (d == xibe_pkg::REG_RAX && uimm > 64'h7F) begin
          // short accumulator form
          desc_nxt.bytes[1] = (in_cmd == xibe_pkg::CMD_SUBIMM) ? 8'h2D : 8'h05;
          desc_nxt.bytes[2] = uimm[7:0];
          desc_nxt.bytes[3] = uimm[15:8];
          desc_nxt.bytes[4] = uimm[23:16];
          desc_nxt.bytes[5] = uimm[31:24];
          n = 4'd6;
        end else if (uimm <= 64'h7F) begin
          desc_nxt.bytes[1] = xibe_pkg::OP_GRP1_IB;
          desc_nxt.bytes[2] = ext | {5'h0, d};
          desc_nxt.bytes[3] = uimm[7:0];
          n = 4'd4;
        end else begin
          desc_nxt.bytes[1] = xibe_pkg::OP_GRP1_ID;
          desc_nxt.bytes[2] = ext | {5'h0, d};
          desc_nxt.bytes[3] = uimm[7:0];
          desc_nxt.bytes[4] = uimm[15:8];
          desc_nxt.bytes[5] = uimm[23:16];
          desc_nxt.bytes[6] = uimm[31:24];
          n = 4'd7;
        end
      end
    end else if (in_cmd >= xibe_pkg::CMD_ALU_FIRST && in_cmd <= xibe_pkg::CMD_MUL_LAST) begin
      if (in_size_code == xibe_pkg::SZ_QWORD) begin
        desc_nxt.bytes[n] = xibe_pkg::OP_REX_W; n = n + 4'd1;
      end else if (in_size_code == xibe_pkg::SZ_WORD) begin
        desc_nxt.bytes[n] = xibe_pkg::OP_OPSIZE; n = n + 4'd1;
      end else if (in_size_code == xibe_pkg::SZ_BYTE &&
                   (d[2] || (in_cmd <= xibe_pkg::CMD_ALU_LAST && s[2]))) begin
        // byte access to SPL..DIL needs a plain REX
        desc_nxt.bytes[n] = xibe_pkg::OP_REX; n = n + 4'd1;
      end
      if (in_cmd <= xibe_pkg::CMD_ALU_LAST) begin
        desc_nxt.bytes[n] = xibe_pkg::alu_opcode(3'(in_cmd - xibe_pkg::CMD_ALU_FIRST))
                            + {7'h0, in_size_code != xibe_pkg::SZ_BYTE};
        n = n + 4'd1;
        desc_nxt.bytes[n] = {2'b11, s, d}; n = n + 4'd1;
      end else begin
        desc_nxt.bytes[n] = (in_size_code != xibe_pkg::SZ_BYTE) ? 8'hF7 : 8'hF6;
        n = n + 4'd1;
        desc_nxt.bytes[n] = xibe_pkg::mul_modrm(2'(in_cmd - xibe_pkg::CMD_MUL_FIRST))
                            | {5'h0, d};
        n = n + 4'd1;
      end
    end else if (in_cmd == xibe_pkg::CMD_MOV) begin
      desc_nxt.bytes[0] = xibe_pkg::OP_REX_W;
      desc_nxt.bytes[1] = 8'h89;
      desc_nxt.bytes[2] = {2'b11, s, d};
      n = 4'd3;
    end else if (in_cmd == xibe_pkg::CMD_STORE || in_cmd == xibe_pkg::CMD_LOAD) begin
      if ((d != xibe_pkg::REG_RAX && d != xibe_pkg::REG_RDX) ||
          (s != xibe_pkg::REG_RAX && s != xibe_pkg::REG_RDX) || d == s) begin
        desc_nxt.kind = xibe_pkg::KIND_ERROR;
      end else begin
        if (in_size_code == xibe_pkg::SZ_QWORD) begin
          desc_nxt.bytes[n] = xibe_pkg::OP_REX_W; n = n + 4'd1;
        end else if (in_size_code == xibe_pkg::SZ_WORD) begin
          desc_nxt.bytes[n] = xibe_pkg::OP_OPSIZE; n = n + 4'd1;
        end
        if (in_cmd == xibe_pkg::CMD_STORE) begin
          desc_nxt.bytes[n] = (in_size_code == xibe_pkg::SZ_BYTE) ? 8'h88 : 8'h89;
          n = n + 4'd1;
          desc_nxt.bytes[n] = (d == xibe_pkg::REG_RDX) ? 8'h02 : 8'h10;
          n = n + 4'd1;
        end else begin
          desc_nxt.bytes[n] = (in_size_code == xibe_pkg::SZ_BYTE) ? 8'h8A : 8'h8B;
          n = n + 4'd1;
          desc_nxt.bytes[n] = (d == xibe_pkg::REG_RAX) ? 8'h02 : 8'h10;
          n = n + 4'd1;
        end
      end
    end else if (in_cmd == xibe_pkg::CMD_PUSH || in_cmd == xibe_pkg::CMD_POP) begin
      if (d == xibe_pkg::REG_RCX || d == xibe_pkg::REG_RBX) begin
        desc_nxt.kind = xibe_pkg::KIND_ERROR;
      end else begin
        desc_nxt.bytes[0] = ((in_cmd == xibe_pkg::CMD_PUSH) ? 8'h50 : 8'h58) | {5'h0, d};
        n = 4'd1;
      end
    end else if (in_cmd == xibe_pkg::CMD_PUSHIMM) begin
      if (fits8) begin
        desc_nxt.bytes[0] = xibe_pkg::OP_PUSH_IB;
        desc_nxt.bytes[1] = uimm[7:0];
        n = 4'd2;
      end else if (fits32) begin
        desc_nxt.bytes[0] = xibe_pkg::OP_PUSH_ID;
        for (int i = 0; i < 4; i++) desc_nxt.bytes[i+1] = uimm[8*i +: 8];
        n = 4'd5;
      end else begin
        // movabs rax, imm64 ; push rax
        desc_nxt.bytes[0] = xibe_pkg::OP_REX_W;
        desc_nxt.bytes[1] = xibe_pkg::OP_MOV_RI;
        for (int i = 0; i < 8; i++) desc_nxt.bytes[i+2] = uimm[8*i +: 8];
        desc_nxt.bytes[10] = 8'h50;
        n = 4'd11;
      end
    end else if (in_cmd == xibe_pkg::CMD_STACKLOAD || in_cmd == xibe_pkg::CMD_LEA) begin
      if ((d != xibe_pkg::REG_RAX && d != xibe_pkg::REG_RDX) ||
          (s != xibe_pkg::REG_RSP && s != xibe_pkg::REG_RBP) || !fits32) begin
        desc_nxt.kind = xibe_pkg::KIND_ERROR;
      end else begin
        if (in_cmd == xibe_pkg::CMD_LEA) begin
          desc_nxt.bytes[n] = xibe_pkg::OP_REX_W; n = n + 4'd1;
          desc_nxt.bytes[n] = 8'h8D;              n = n + 4'd1;
        end else begin
          if (in_size_code == xibe_pkg::SZ_QWORD) begin
            desc_nxt.bytes[n] = xibe_pkg::OP_REX_W; n = n + 4'd1;
          end else if (in_size_code == xibe_pkg::SZ_WORD) begin
            desc_nxt.bytes[n] = xibe_pkg::OP_OPSIZE; n = n + 4'd1;
          end
          desc_nxt.bytes[n] = (in_size_code == xibe_pkg::SZ_BYTE) ? 8'h8A : 8'h8B;
          n = n + 4'd1;
        end
        if (s == xibe_pkg::REG_RSP) begin
          // RSP base always needs a SIB byte
          if (imm_zero) begin
            desc_nxt.bytes[n] = 8'h04 | r_bits;         n = n + 4'd1;
            desc_nxt.bytes[n] = xibe_pkg::OP_SIB_RSP;   n = n + 4'd1;
          end else if (fits8) begin
            desc_nxt.bytes[n] = 8'h44 | r_bits;         n = n + 4'd1;
            desc_nxt.bytes[n] = xibe_pkg::OP_SIB_RSP;   n = n + 4'd1;
            desc_nxt.bytes[n] = uimm[7:0];              n = n + 4'd1;
          end else begin
            desc_nxt.bytes[n] = 8'h84 | r_bits;         n = n + 4'd1;
            desc_nxt.bytes[n] = xibe_pkg::OP_SIB_RSP;   n = n + 4'd1;
            for (int i = 0; i < 4; i++) begin
              desc_nxt.bytes[n] = uimm[8*i +: 8];       n = n + 4'd1;
            end
          end
        end else begin
          if (fits8) begin
            desc_nxt.bytes[n] = 8'h45 | r_bits;         n = n + 4'd1;
            desc_nxt.bytes[n] = uimm[7:0];              n = n + 4'd1;
          end else begin
            desc_nxt.bytes[n] = 8'h85 | r_bits;         n = n + 4'd1;
            for (int i = 0; i < 4; i++) begin
              desc_nxt.bytes[n] = uimm[8*i +: 8];       n = n + 4'd1;
            end
          end
        end
      end
    end else begin
      desc_nxt.kind = xibe_pkg::KIND_ERROR;
    end

    desc_nxt.nbytes = n;
  end

  assign in_ready = !front_v_r || desc_ready;
  assign accept   = in_valid && in_ready;
  assign push     = front_v_r && desc_ready;

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept)    front_v_nxt = 1'b1;
    else if (push) front_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

  assign desc_valid = front_v_r;
  assign desc       = desc_r;

endmodule

// ===== rtl/xibe_queue.sv =====
// Short descriptor queue between the front end and the byte serializer.
module xibe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             not_full,
  input  xibe_pkg::desc_t  wr_desc,
  input  logic             pop,
  output logic             not_empty,
  output xibe_pkg::desc_t  rd_desc
);

  xibe_pkg::desc_t                 q_r [xibe_pkg::QDEPTH];
  logic [xibe_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [xibe_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [xibe_pkg::QPTR_W:0]       cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != (xibe_pkg::QPTR_W+1)'(xibe_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_desc   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= wr_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/xibe_back.sv =====
// Back end: serializes descriptor bytes, keeps byte count and terminator flag.
module xibe_back #(
  parameter int POSITION_WIDTH = xibe_pkg::POSITION_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  xibe_pkg::desc_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_code_byte,
  output logic             out_byte_valid,
  output logic [31:0]      out_position,
  output logic             out_is_patch_site,
  output logic             out_terminator,
  output logic             out_error,
  output logic             out_last
);

  logic [POSITION_WIDTH-1:0] count_r, count_nxt;
  logic                      flag_r, flag_nxt;
  logic [3:0]                idx_r, idx_nxt;

  logic        out_valid_r;
  logic [7:0]  code_r;
  logic        bvalid_r, patch_r, term_r, err_r, last_r;
  logic [31:0] pos_r;

  logic        advance, is_bytes, at_end;
  logic [63:0] count_ext;
  logic [7:0]  code_nxt;
  logic        bvalid_nxt, patch_nxt, term_nxt, err_nxt;

  assign advance   = head_valid && (!out_valid_r || out_ready);
  assign is_bytes  = (head.kind == xibe_pkg::KIND_BYTES);
  assign at_end    = !is_bytes || (idx_r == head.nbytes - 4'd1);
  assign pop       = advance && at_end;
  assign count_ext = 64'(count_r);

  always_comb begin
    count_nxt  = count_r;
    flag_nxt   = flag_r;
    idx_nxt    = idx_r;
    code_nxt   = '0;
    bvalid_nxt = 1'b0;
    patch_nxt  = 1'b0;
    term_nxt   = flag_r;
    err_nxt    = 1'b0;
    if (advance) begin
      unique case (head.kind)
        xibe_pkg::KIND_BYTES: begin
          code_nxt   = head.bytes[idx_r];
          bvalid_nxt = 1'b1;
          patch_nxt  = (idx_r == head.patch_idx);
          term_nxt   = head.term;
          flag_nxt   = head.term;
          count_nxt  = count_r + 1'b1;
          idx_nxt    = at_end ? 4'd0 : idx_r + 4'd1;
        end
        xibe_pkg::KIND_LABEL: begin
          flag_nxt = 1'b0;
          term_nxt = 1'b0;
        end
        xibe_pkg::KIND_ERROR: begin
          err_nxt = 1'b1;
        end
        xibe_pkg::KIND_EMPTY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      flag_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
      idx_r   <= idx_nxt;
      if (advance)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (advance) begin
      code_r   <= code_nxt;
      bvalid_r <= bvalid_nxt;
      pos_r    <= count_ext[31:0];
      patch_r  <= patch_nxt;
      term_r   <= term_nxt;
      err_r    <= err_nxt;
      last_r   <= at_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_byte     = code_r;
  assign out_byte_valid    = bvalid_r;
  assign out_position      = pos_r;
  assign out_is_patch_site = patch_r;
  assign out_terminator    = term_r;
  assign out_error         = err_r;
  assign out_last          = last_r;

  // displacement placeholders only occur inside jumps, which end a block
  a_patch_in_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && patch_r |-> bvalid_r && term_r)
    else $error("patch site outside a terminating byte");

  a_single_nonbyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !bvalid_r |-> last_r)
    else $error("byteless result not marked last");

  a_idx_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 4'd0)
    else $error("byte index not rewound after request");

endmodule

// ===== rtl/x86_64_instruction_byte_encoder.sv =====
// Top level of the x86-64 instruction byte encoder.
// Each request is classified by the front end into a registered descriptor
// of up to eleven bytes, queued two deep, and streamed by the back end one
// result per cycle while the queue is not empty and out_ready is high: an
// instruction of n bytes gives n results, an error, label or zero add/sub
// request one byte-less result. The single-byte result port sets throughput;
// requests enter at one per cycle while the queue has room, and pass the
// front-end register, the queue and the back-end output register. Positions
// count from zero after reset and wrap at POSITION_WIDTH bits.
module x86_64_instruction_byte_encoder #(
  parameter int POSITION_WIDTH = xibe_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_cmd,
  input  logic [2:0]         in_dst_reg,
  input  logic [2:0]         in_src_reg,
  input  logic [1:0]         in_size_code,
  input  logic [3:0]         in_cond,
  input  logic signed [63:0] in_imm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_code_byte,
  output logic               out_byte_valid,
  output logic [31:0]        out_position,
  output logic               out_is_patch_site,
  output logic               out_terminator,
  output logic               out_error,
  output logic               out_last
);

  xibe_pkg::desc_t front_desc, head_desc;
  logic            front_valid, q_not_full, q_not_empty, q_pop;

  xibe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_dst_reg   (in_dst_reg),
    .in_src_reg   (in_src_reg),
    .in_size_code (in_size_code),
    .in_cond      (in_cond),
    .in_imm       (in_imm),
    .desc_valid   (front_valid),
    .desc_ready   (q_not_full),
    .desc         (front_desc)
  );

  xibe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid && q_not_full),
    .not_full  (q_not_full),
    .wr_desc   (front_desc),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_desc   (head_desc)
  );

  xibe_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_not_empty),
    .head              (head_desc),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_byte     (out_code_byte),
    .out_byte_valid    (out_byte_valid),
    .out_position      (out_position),
    .out_is_patch_site (out_is_patch_site),
    .out_terminator    (out_terminator),
    .out_error         (out_error),
    .out_last          (out_last)
  );

endmodule
